@@ rtl/core/sbfc_pkg.sv @@
package sbfc_pkg;
  localparam int COORD_BITS_DEF = 32;
  localparam int FRAC_BITS_DEF = 16;
  localparam int OUT_FRAC = 16;
  localparam int NUM_AXES = 3;
  localparam int NUM_REGS = 6;
  localparam int ADDR_BITS = 5;

  typedef enum logic [2:0] {
    REG_MIN_X = 3'd0,
    REG_MIN_Y = 3'd1,
    REG_MIN_Z = 3'd2,
    REG_MAX_X = 3'd3,
    REG_MAX_Y = 3'd4,
    REG_MAX_Z = 3'd5
  } reg_idx_t;

  localparam logic [1:0] NORM_ZERO = 2'b00;
  localparam logic [1:0] NORM_POS = 2'b01;
  localparam logic [1:0] NORM_NEG = 2'b11;
endpackage

@@ rtl/core/sbfc_if.sv @@
interface sbfc_in_if #(
  parameter int COORD_BITS = 32
);
  logic valid;
  logic ready;
  logic signed [COORD_BITS-1:0] moving_min_x;
  logic signed [COORD_BITS-1:0] moving_min_y;
  logic signed [COORD_BITS-1:0] moving_min_z;
  logic signed [COORD_BITS-1:0] moving_max_x;
  logic signed [COORD_BITS-1:0] moving_max_y;
  logic signed [COORD_BITS-1:0] moving_max_z;
  logic signed [COORD_BITS-1:0] disp_x;
  logic signed [COORD_BITS-1:0] disp_y;
  logic signed [COORD_BITS-1:0] disp_z;
  modport source (output valid, moving_min_x, moving_min_y, moving_min_z, moving_max_x,
                  moving_max_y, moving_max_z, disp_x, disp_y, disp_z, input ready);
  modport sink (input valid, moving_min_x, moving_min_y, moving_min_z, moving_max_x,
                moving_max_y, moving_max_z, disp_x, disp_y, disp_z, output ready);
endinterface

interface sbfc_out_if;
  logic valid;
  logic ready;
  logic hit;
  logic [16:0] contact_fraction;
  logic signed [1:0] normal_x;
  logic signed [1:0] normal_y;
  logic signed [1:0] normal_z;
  modport source (output valid, hit, contact_fraction, normal_x, normal_y, normal_z,
                  input ready);
  modport sink (input valid, hit, contact_fraction, normal_x, normal_y, normal_z,
                output ready);
endinterface

@@ rtl/core/sbfc_axis_lane.sv @@
// One axis: gaps, then two pipelined restoring dividers, one per slab time.
module sbfc_axis_lane import sbfc_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  localparam int GW = COORD_BITS + 1,
  localparam int TW = FRAC_BITS + 5,
  localparam int QB = FRAC_BITS + 3
) (
  input  logic clk,
  input  logic adv,
  input  logic signed [COORD_BITS-1:0] mmin,
  input  logic signed [COORD_BITS-1:0] mmax,
  input  logic signed [COORD_BITS-1:0] omin,
  input  logic signed [COORD_BITS-1:0] omax,
  input  logic signed [COORD_BITS-1:0] disp,
  output logic signed [TW-1:0] entry,
  output logic signed [TW-1:0] exit_t,
  output logic [COORD_BITS-1:0] amov,
  output logic still_apart,
  output logic disp_pos,
  output logic still
);
  localparam int NS = QB;
  localparam int RW = GW + 1;
  // numerator bits of an that are brought down one per stage
  localparam int NB = QB - FRAC_BITS;

  // per-stage pipeline of two dividers sharing the divisor
  logic [GW-1:0] an_r [2][NS+1];
  logic [RW-1:0] rm_r [2][NS+1];
  logic [QB-1:0] q_r [2][NS+1];
  logic          ng_r [2][NS+1];
  logic          sat_r [2][NS+1];
  logic [GW-1:0] ad_r [NS+1];
  logic          still_r [NS+1];
  logic          apart_r [NS+1];
  logic          pos_r [NS+1];

  logic signed [GW-1:0] ga, gb, dd;
  logic [GW-1:0] aa, ab, adv_d;
  logic signed [TW-1:0] qa, qb, mag0, mag1;

  always_comb begin
    ga = GW'(omin) - GW'(mmax);
    gb = GW'(omax) - GW'(mmin);
    dd = GW'(disp);
    aa = ga[GW-1] ? GW'(-ga) : GW'(ga);
    ab = gb[GW-1] ? GW'(-gb) : GW'(gb);
    adv_d = dd[GW-1] ? GW'(-dd) : GW'(dd);
  end

  // the quotient stays below 2^QB unless saturated, so the partial remainder
  // starts from the numerator bits above the top quotient bit
  always_ff @(posedge clk) begin
    if (adv) begin
      an_r[0][0] <= aa;
      an_r[1][0] <= ab;
      ng_r[0][0] <= ga[GW-1] ^ dd[GW-1];
      ng_r[1][0] <= gb[GW-1] ^ dd[GW-1];
      sat_r[0][0] <= {2'b0, aa} >= {adv_d, 2'b0};
      sat_r[1][0] <= {2'b0, ab} >= {adv_d, 2'b0};
      rm_r[0][0] <= RW'(aa >> NB);
      rm_r[1][0] <= RW'(ab >> NB);
      q_r[0][0] <= '0;
      q_r[1][0] <= '0;
      ad_r[0] <= adv_d;
      still_r[0] <= (disp == '0);
      apart_r[0] <= (mmax <= omin) || (omax <= mmin);
      pos_r[0] <= ~disp[COORD_BITS-1] && (disp != '0);
    end
  end

  // stage s brings down one numerator bit (quotient bit QB-1-s).
  // the numerator is an << FRAC_BITS, so below the low bits of an come zeros.
  for (genvar s = 0; s < NS; s++) begin : g_st
    for (genvar h = 0; h < 2; h++) begin : g_h
      logic [RW:0] sh;
      logic [RW:0] df;
      logic        nb;
      if (s < NB) begin : g_nb
        assign nb = an_r[h][s][NB-1-s];
      end else begin : g_nz
        assign nb = 1'b0;
      end
      always_comb begin
        sh = {rm_r[h][s], nb};
        df = sh - {2'b0, ad_r[s]};
      end
      always_ff @(posedge clk) begin
        if (adv) begin
          an_r[h][s+1] <= an_r[h][s];
          ng_r[h][s+1] <= ng_r[h][s];
          sat_r[h][s+1] <= sat_r[h][s];
          if (!df[RW]) begin
            rm_r[h][s+1] <= df[RW-1:0];
            q_r[h][s+1] <= q_r[h][s] | (QB'(1) << (QB - 1 - s));
          end else begin
            rm_r[h][s+1] <= sh[RW-1:0];
            q_r[h][s+1] <= q_r[h][s];
          end
        end
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        ad_r[s+1] <= ad_r[s];
        still_r[s+1] <= still_r[s];
        apart_r[s+1] <= apart_r[s];
        pos_r[s+1] <= pos_r[s];
      end
    end
  end

  always_comb begin
    mag0 = sat_r[0][NS] ? TW'(4 << FRAC_BITS) : TW'(q_r[0][NS]);
    mag1 = sat_r[1][NS] ? TW'(4 << FRAC_BITS) : TW'(q_r[1][NS]);
    qa = ng_r[0][NS] ? -mag0 : mag0;
    qb = ng_r[1][NS] ? -mag1 : mag1;
    if (still_r[NS]) begin
      entry = -TW'(8 << FRAC_BITS);
      exit_t = TW'(8 << FRAC_BITS);
    end else begin
      entry = (qa < qb) ? qa : qb;
      exit_t = (qa < qb) ? qb : qa;
    end
    amov = ad_r[NS][COORD_BITS-1:0];
    still_apart = still_r[NS] && apart_r[NS];
    disp_pos = pos_r[NS];
    still = still_r[NS];
  end
endmodule

@@ rtl/core/sbfc_merge.sv @@
// Combine three axis lanes into hit, fraction and normal.
module sbfc_merge import sbfc_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  localparam int TW = FRAC_BITS + 5
) (
  input  logic signed [TW-1:0] en [NUM_AXES],
  input  logic signed [TW-1:0] ex [NUM_AXES],
  input  logic [COORD_BITS-1:0] amov [NUM_AXES],
  input  logic apart [NUM_AXES],
  input  logic still [NUM_AXES],
  input  logic pos [NUM_AXES],
  input  logic flat,
  output logic hit,
  output logic [16:0] frac,
  output logic [1:0] nrm [NUM_AXES]
);
  logic signed [TW-1:0] ent, ext, fe;
  logic [1:0] ax;
  logic signed [TW-1:0] ben;
  logic [COORD_BITS-1:0] bmv;
  always_comb begin
    ent = en[0];
    ext = ex[0];
    ax = 2'd0;
    ben = en[0];
    bmv = amov[0];
    for (int k = 1; k < NUM_AXES; k++) begin
      if (en[k] > ent) ent = en[k];
      if (ex[k] < ext) ext = ex[k];
      if (en[k] > ben || (en[k] == ben && amov[k] > bmv)) begin
        ben = en[k];
        bmv = amov[k];
        ax = 2'(k);
      end
    end
    hit = !flat && !(still[0] && still[1] && still[2]) &&
          !apart[0] && !apart[1] && !apart[2] &&
          !(ent > ext) && (ext > 0) && !(ent > TW'(1 << FRAC_BITS));
    fe = ent[TW-1] ? '0 : ent;
    if (FRAC_BITS >= OUT_FRAC) frac = 17'(fe >>> (FRAC_BITS - OUT_FRAC));
    else frac = 17'(fe <<< (OUT_FRAC - FRAC_BITS));
    for (int k = 0; k < NUM_AXES; k++)
      nrm[k] = (hit && ax == 2'(k)) ? (pos[k] ? NORM_NEG : NORM_POS) : NORM_ZERO;
    if (!hit) frac = '0;
  end
endmodule

@@ rtl/core/swept_box_first_contact_unit.sv @@
// Pipeline: coordinates default to Q16.16; each axis lane runs one restoring-divider
//   stage per quotient bit, then the lanes merge into the output register.
// Throughput: one request per cycle while the pipeline advances; three axis lanes run side by side.
// The pipeline advances unless the output register holds an untaken result.
// Reset (synchronous, rst_n low): clears valids and obstacle registers to 0.
module swept_box_first_contact_unit import sbfc_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  sbfc_in_if.sink in_if,
  sbfc_out_if.source out_if,
  input  logic cfg_psel,
  input  logic cfg_penable,
  input  logic cfg_pwrite,
  input  logic [ADDR_BITS-1:0] cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic cfg_pready
);
  localparam int TW = FRAC_BITS + 5;
  localparam int LAT = FRAC_BITS + 3;

  logic signed [COORD_BITS-1:0] omin_r [NUM_AXES];
  logic signed [COORD_BITS-1:0] omax_r [NUM_AXES];
  logic [2:0] widx;
  logic adv;
  logic [LAT:0] vld_r;
  logic [LAT:0] flat_r;
  logic flat_in;

  assign cfg_pready = 1'b1;
  assign widx = cfg_paddr[4:2];

  // register file: write on access phase, decoded by word address
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NUM_AXES; k++) begin
        omin_r[k] <= '0;
        omax_r[k] <= '0;
      end
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      unique case (widx)
        REG_MIN_X: omin_r[0] <= COORD_BITS'(signed'(cfg_pwdata));
        REG_MIN_Y: omin_r[1] <= COORD_BITS'(signed'(cfg_pwdata));
        REG_MIN_Z: omin_r[2] <= COORD_BITS'(signed'(cfg_pwdata));
        REG_MAX_X: omax_r[0] <= COORD_BITS'(signed'(cfg_pwdata));
        REG_MAX_Y: omax_r[1] <= COORD_BITS'(signed'(cfg_pwdata));
        REG_MAX_Z: omax_r[2] <= COORD_BITS'(signed'(cfg_pwdata));
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (widx)
      REG_MIN_X: cfg_prdata = 32'(omin_r[0]);
      REG_MIN_Y: cfg_prdata = 32'(omin_r[1]);
      REG_MIN_Z: cfg_prdata = 32'(omin_r[2]);
      REG_MAX_X: cfg_prdata = 32'(omax_r[0]);
      REG_MAX_Y: cfg_prdata = 32'(omax_r[1]);
      REG_MAX_Z: cfg_prdata = 32'(omax_r[2]);
      default:   cfg_prdata = '0;
    endcase
  end

  // hold the whole pipe while the output register is full and not taken
  assign adv = !out_if.valid || out_if.ready;
  assign in_if.ready = adv;

  assign flat_in = (in_if.moving_max_x <= in_if.moving_min_x) ||
                   (in_if.moving_max_y <= in_if.moving_min_y) ||
                   (in_if.moving_max_z <= in_if.moving_min_z) ||
                   (omax_r[0] <= omin_r[0]) || (omax_r[1] <= omin_r[1]) ||
                   (omax_r[2] <= omin_r[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (adv) vld_r <= {vld_r[LAT-1:0], in_if.valid};
  end
  always_ff @(posedge clk) begin
    if (adv) flat_r <= {flat_r[LAT-1:0], flat_in};
  end

  logic signed [COORD_BITS-1:0] mn [NUM_AXES], mx [NUM_AXES], dp [NUM_AXES];
  logic signed [TW-1:0] en [NUM_AXES], ex [NUM_AXES];
  logic [COORD_BITS-1:0] amov [NUM_AXES];
  logic apart [NUM_AXES], still [NUM_AXES], pos [NUM_AXES];

  assign mn[0] = in_if.moving_min_x;
  assign mn[1] = in_if.moving_min_y;
  assign mn[2] = in_if.moving_min_z;
  assign mx[0] = in_if.moving_max_x;
  assign mx[1] = in_if.moving_max_y;
  assign mx[2] = in_if.moving_max_z;
  assign dp[0] = in_if.disp_x;
  assign dp[1] = in_if.disp_y;
  assign dp[2] = in_if.disp_z;

  for (genvar a = 0; a < NUM_AXES; a++) begin : g_lane
    sbfc_axis_lane #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_lane (
      .clk(clk), .adv(adv), .mmin(mn[a]), .mmax(mx[a]), .omin(omin_r[a]),
      .omax(omax_r[a]), .disp(dp[a]), .entry(en[a]), .exit_t(ex[a]),
      .amov(amov[a]), .still_apart(apart[a]), .disp_pos(pos[a]), .still(still[a])
    );
  end

  logic m_hit;
  logic [16:0] m_frac;
  logic [1:0] m_nrm [NUM_AXES];

  sbfc_merge #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_merge (
    .en(en), .ex(ex), .amov(amov), .apart(apart), .still(still), .pos(pos),
    .flat(flat_r[LAT]), .hit(m_hit), .frac(m_frac), .nrm(m_nrm)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_if.valid <= 1'b0;
    end else if (adv) begin
      out_if.valid <= vld_r[LAT];
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      out_if.hit <= m_hit;
      out_if.contact_fraction <= m_frac;
      out_if.normal_x <= m_nrm[0];
      out_if.normal_y <= m_nrm[1];
      out_if.normal_z <= m_nrm[2];
    end
  end
endmodule
